@@ hdl/aeg_pkg.sv @@
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared widths, fixed-point constants and codes for the accent envelope core.
// ----------------------------------------------------------------------------
package aeg_pkg;

  localparam int FRAC_BITS = 32;

  localparam int LVL_W   = FRAC_BITS + 1;  // env level, block peak (<= 1.0)
  localparam int PM_W    = FRAC_BITS + 2;  // peak multiplier (<= 2.0)
  localparam int COEF_W  = 32;
  localparam int BASE_W  = 33;
  localparam int VEL_W   = 16;
  localparam int ACC_W   = 16;
  localparam int OUT_W   = 18;
  localparam int FAC_W   = 33;             // 0.2 + vel*accent, 32 frac bits
  localparam int CFG_W   = 33;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_W  = (PM_W > FAC_W) ? PM_W : FAC_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int MCNT_W = $clog2(MUL_W + 1);

  localparam int Q_W    = FRAC_BITS - 3;   // 2^(2F)/(10*pm) < 2^(F-3)
  localparam int DIV_W  = FRAC_BITS + 5;   // 10*pm < 2^(F+5)
  localparam int DCNT_W = $clog2(Q_W + 1);

  localparam int ASUM_W = (COEF_W + 1 > LVL_W) ? COEF_W + 1 : LVL_W;
  localparam int DSUM_W = ASUM_W + 1;
  localparam int LVL_SHIFT = FRAC_BITS + 16;
  localparam int LFULL_W   = PROD_W - LVL_SHIFT;

  localparam logic [DIV_W-1:0] DIV_INIT = DIV_W'(1) << (FRAC_BITS + 3);
  localparam logic [PM_W-1:0]  ONE_PM   = PM_W'(1) << FRAC_BITS;
  localparam logic [PM_W-1:0]  TWO_PM   = PM_W'(1) << (FRAC_BITS + 1);
  localparam logic [LVL_W-1:0] ONE_LVL  = LVL_W'(1) << FRAC_BITS;

  localparam logic [31:0]      POINT_TWO = 32'd858993459;
  localparam logic [OUT_W-1:0] LEVEL_MAX = 18'd157286;

  localparam logic [COEF_W-1:0]        ATTACK_COEFF_RST = 32'd4266440000;
  localparam logic [COEF_W-1:0]        ATTACK_BASE_RST  = 32'd37074000;
  localparam logic [COEF_W-1:0]        DECAY_COEFF_RST  = 32'd4290483000;
  localparam logic signed [BASE_W-1:0] DECAY_BASE_RST   = -33'sd448;
  localparam logic [ACC_W-1:0]         ACCENT_RST       = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCENT       = 3'd4;

  localparam logic [1:0] FN_NOTE_ON  = 2'd0;
  localparam logic [1:0] FN_NOTE_OFF = 2'd1;
  localparam logic [1:0] FN_TICK     = 2'd2;
  localparam logic [1:0] FN_RESET    = 2'd3;

endpackage

@@ hdl/aeg_serial_mul.sv @@
// ----------------------------------------------------------------------------
// aeg_serial_mul
// Shift-add multiplier, one multiplier bit per clock, full-width product.
// ----------------------------------------------------------------------------
module aeg_serial_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [aeg_pkg::MUL_W-1:0]   op_a,
  input  logic [aeg_pkg::MUL_W-1:0]   op_b,
  output logic                        busy,
  output logic                        done,
  output logic [aeg_pkg::PROD_W-1:0]  prod
);
  import aeg_pkg::*;

  logic [MUL_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [MUL_W:0]    sum;

  assign sum = {1'b0, p_r[PROD_W-1:MUL_W]} + (b_r[0] ? {1'b0, a_r} : '0);

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = op_a;
      b_nxt   = op_b;
      p_nxt   = '0;
      cnt_nxt = MCNT_W'(MUL_W);
    end else if (cnt_r != '0) begin
      p_nxt    = {sum, p_r[MUL_W-1:1]};
      b_nxt    = b_r >> 1;
      cnt_nxt  = cnt_r - MCNT_W'(1);
      done_nxt = (cnt_r == MCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign prod = p_r;

endmodule

@@ hdl/aeg_serial_div.sv @@
// ----------------------------------------------------------------------------
// aeg_serial_div
// Restoring divider for 2^(2F) / divisor, one quotient bit per clock.
// ----------------------------------------------------------------------------
module aeg_serial_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [aeg_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [aeg_pkg::Q_W-1:0]   quot
);
  import aeg_pkg::*;

  logic [DIV_W-1:0]  d_r, d_nxt, rem_r, rem_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;
  logic              ge;

  // numerator bits below the initial remainder are all zero
  assign trial = {rem_r, 1'b0};
  assign ge    = (trial >= {1'b0, d_r});

  always_comb begin
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      d_nxt   = divisor;
      rem_nxt = DIV_INIT;
      q_nxt   = '0;
      cnt_nxt = DCNT_W'(Q_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DIV_W'(trial - {1'b0, d_r}) : DIV_W'(trial);
      q_nxt    = {q_r[Q_W-2:0], ge};
      cnt_nxt  = cnt_r - DCNT_W'(1);
      done_nxt = (cnt_r == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign quot = q_r;

endmodule

@@ hdl/accent_envelope_generator_core.sv @@
// ----------------------------------------------------------------------------
// accent_envelope_generator_core
// Exponential attack/decay accent envelope with block-peak level output.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Note off, reset and a note on into an idle
// envelope are handled in the idle state. A note on over an active envelope
// waits on the bit-serial divider that forms the peak multiplier increment.
// A sample tick in attack or decay runs one multiply on the envelope; one in
// idle resets the peak multiplier and updates the block peak. A tick that
// ends a block runs four multiplies from attack or decay and three from idle,
// plus any wait for the output register to free up. All multiplies use the
// one shared bit-serial multiplier, which retires one multiplier bit per
// clock.
// The result sits in an output register, so the next beat is taken while a
// level waits to be read.
module accent_envelope_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [aeg_pkg::VEL_W-1:0]     in_velocity,
  input  logic                          in_block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aeg_pkg::OUT_W-1:0]     out_level,
  input  logic                          cfg_we,
  input  logic [aeg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aeg_pkg::CFG_W-1:0]     cfg_data
);
  import aeg_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TMUL = 3'd1;
  localparam logic [2:0] ST_PEAK = 3'd2;
  localparam logic [2:0] ST_EMUL = 3'd3;
  localparam logic [2:0] ST_VMUL = 3'd4;
  localparam logic [2:0] ST_FMUL = 3'd5;
  localparam logic [2:0] ST_HOLD = 3'd6;
  localparam logic [2:0] ST_DIV  = 3'd7;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ATTACK = 2'd1;
  localparam logic [1:0] PH_DECAY  = 2'd2;

  logic [COEF_W-1:0]        attack_coeff_r, attack_base_r, decay_coeff_r;
  logic signed [BASE_W-1:0] decay_base_r;
  logic [ACC_W-1:0]         accent_r;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [LVL_W-1:0]  env_r, env_nxt, bp_r, bp_nxt;
  logic [PM_W-1:0]   pm_r, pm_nxt, eprod_r, eprod_nxt;
  logic [VEL_W-1:0]  vel_r, vel_nxt;
  logic              last_r, last_nxt;
  logic              mgo_r, mgo_nxt, dgo_r, dgo_nxt;
  logic [MUL_W-1:0]  opa_r, opa_nxt, opb_r, opb_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [OUT_W-1:0]  lvl_r, lvl_nxt, out_level_r, out_level_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              mul_busy, mul_done, div_busy, div_done;
  logic [PROD_W-1:0] mul_p;
  logic [Q_W-1:0]    div_q;

  logic [COEF_W-1:0]        prod_f;
  logic [ASUM_W-1:0]        av;
  logic signed [DSUM_W-1:0] dv;
  logic [LVL_W-1:0]         peak;
  logic [FAC_W-1:0]         factor;
  logic [LFULL_W-1:0]       lvl_full;
  logic [PM_W-1:0]          pm_sum;

  aeg_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mgo_r),
    .op_a  (opa_r),
    .op_b  (opb_r),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_p)
  );

  aeg_serial_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dgo_r),
    .divisor (dvs_r),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_q)
  );

  assign prod_f   = mul_p[FRAC_BITS +: COEF_W];
  assign av       = ASUM_W'(prod_f) + ASUM_W'(attack_base_r);
  assign dv       = $signed(DSUM_W'(prod_f)) + DSUM_W'(decay_base_r);
  assign peak     = (env_r > bp_r) ? env_r : bp_r;
  assign factor   = FAC_W'(POINT_TWO) + FAC_W'(mul_p[31:0]);
  assign lvl_full = mul_p[PROD_W-1:LVL_SHIFT];
  assign pm_sum   = pm_r + PM_W'(div_q);

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    env_nxt       = env_r;
    bp_nxt        = bp_r;
    pm_nxt        = pm_r;
    eprod_nxt     = eprod_r;
    vel_nxt       = vel_r;
    last_nxt      = last_r;
    mgo_nxt       = 1'b0;
    dgo_nxt       = 1'b0;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    dvs_nxt       = dvs_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_level_nxt = out_level_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_NOTE_ON: begin
              vel_nxt   = in_velocity;
              phase_nxt = PH_ATTACK;
              if (phase_r != PH_IDLE) begin
                dvs_nxt   = (DIV_W'(pm_r) << 3) + (DIV_W'(pm_r) << 1);
                dgo_nxt   = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            FN_NOTE_OFF: begin
              if (phase_r == PH_ATTACK) phase_nxt = PH_DECAY;
            end
            FN_TICK: begin
              last_nxt = in_block_end;
              opa_nxt  = MUL_W'(env_r);
              case (phase_r)
                PH_ATTACK: begin
                  opb_nxt   = MUL_W'(attack_coeff_r);
                  mgo_nxt   = 1'b1;
                  state_nxt = ST_TMUL;
                end
                PH_DECAY: begin
                  opb_nxt   = MUL_W'(decay_coeff_r);
                  mgo_nxt   = 1'b1;
                  state_nxt = ST_TMUL;
                end
                default: begin
                  pm_nxt    = ONE_PM;
                  state_nxt = ST_PEAK;
                end
              endcase
            end
            default: begin
              phase_nxt = PH_IDLE;
              env_nxt   = '0;
            end
          endcase
        end
      end
      ST_TMUL: begin
        if (mul_done) begin
          if (phase_r == PH_ATTACK) begin
            if (av >= ASUM_W'(ONE_LVL)) begin
              env_nxt   = ONE_LVL;
              phase_nxt = PH_DECAY;
            end else begin
              env_nxt = LVL_W'(av);
            end
          end else begin
            if (dv[DSUM_W-1] || dv == '0) begin
              env_nxt   = '0;
              phase_nxt = PH_IDLE;
            end else if ($unsigned(dv) > DSUM_W'(ONE_LVL)) begin
              env_nxt = ONE_LVL;
            end else begin
              env_nxt = LVL_W'($unsigned(dv));
            end
          end
          state_nxt = ST_PEAK;
        end
      end
      ST_PEAK: begin
        bp_nxt = peak;
        if (last_r) begin
          opa_nxt   = MUL_W'(pm_r);
          opb_nxt   = MUL_W'(peak);
          mgo_nxt   = 1'b1;
          state_nxt = ST_EMUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMUL: begin
        if (mul_done) begin
          eprod_nxt = mul_p[FRAC_BITS +: PM_W];
          bp_nxt    = '0;
          opa_nxt   = MUL_W'(vel_r);
          opb_nxt   = MUL_W'(accent_r);
          mgo_nxt   = 1'b1;
          state_nxt = ST_VMUL;
        end
      end
      ST_VMUL: begin
        if (mul_done) begin
          opa_nxt   = MUL_W'(eprod_r);
          opb_nxt   = MUL_W'(factor);
          mgo_nxt   = 1'b1;
          state_nxt = ST_FMUL;
        end
      end
      ST_FMUL: begin
        if (mul_done) begin
          lvl_nxt   = (lvl_full > LFULL_W'(LEVEL_MAX)) ? LEVEL_MAX : OUT_W'(lvl_full);
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = lvl_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          pm_nxt    = (pm_sum > TWO_PM) ? TWO_PM : pm_sum;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      env_r       <= '0;
      bp_r        <= '0;
      pm_r        <= ONE_PM;
      vel_r       <= '0;
      mgo_r       <= 1'b0;
      dgo_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      env_r       <= env_nxt;
      bp_r        <= bp_nxt;
      pm_r        <= pm_nxt;
      vel_r       <= vel_nxt;
      mgo_r       <= mgo_nxt;
      dgo_r       <= dgo_nxt;
      out_valid_r <= out_valid_nxt;
    end
    eprod_r     <= eprod_nxt;
    last_r      <= last_nxt;
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    dvs_r       <= dvs_nxt;
    lvl_r       <= lvl_nxt;
    out_level_r <= out_level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_coeff_r <= ATTACK_COEFF_RST;
      attack_base_r  <= ATTACK_BASE_RST;
      decay_coeff_r  <= DECAY_COEFF_RST;
      decay_base_r   <= DECAY_BASE_RST;
      accent_r       <= ACCENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK_COEFF: attack_coeff_r <= cfg_data[COEF_W-1:0];
        CFG_ATTACK_BASE:  attack_base_r  <= cfg_data[COEF_W-1:0];
        CFG_DECAY_COEFF:  decay_coeff_r  <= cfg_data[COEF_W-1:0];
        CFG_DECAY_BASE:   decay_base_r   <= $signed(cfg_data[BASE_W-1:0]);
        CFG_ACCENT:       accent_r       <= cfg_data[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  a_level_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_level_r <= LEVEL_MAX)
    else $error("output level above saturation limit");

  a_pm_range: assert property (@(posedge clk) disable iff (!rst_n)
    pm_r >= ONE_PM && pm_r <= TWO_PM)
    else $error("peak multiplier out of range");

  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ONE_LVL && bp_r <= ONE_LVL)
    else $error("envelope or block peak above 1.0");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mul_busy && !div_busy && !mgo_r && !dgo_r)
    else $error("arithmetic unit active while taking beats");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_TMUL || state_r == ST_EMUL ||
                  state_r == ST_VMUL || state_r == ST_FMUL))
    else $error("multiplier finished outside a multiply step");

endmodule
